>>> src/iff_pkg.sv
// types, constants and helpers shared by the integer field formatter
`timescale 1ns / 1ps
`default_nettype none

package iff_pkg;

  typedef enum logic [2:0] {
    KIND_SDEC = 3'd0,
    KIND_UDEC = 3'd1,
    KIND_LHEX = 3'd2,
    KIND_UHEX = 3'd3,
    KIND_PTR  = 3'd4
  } kind_t;

  localparam int DigW   = 4;
  localparam int MaxDig = 10;
  localparam int DigsW  = DigW * MaxDig;

  localparam logic [31:0] DecRecip = 32'hCCCC_CCCD;

  localparam logic [7:0] CharZero  = 8'h30;
  localparam logic [7:0] CharX     = 8'h78;
  localparam logic [7:0] CharMinus = 8'h2d;
  localparam logic [7:0] CharSpace = 8'h20;
  localparam logic [7:0] CharLowA  = 8'h61;
  localparam logic [7:0] CharUpA   = 8'h41;

  typedef struct packed {
    logic [DigsW-1:0] digs;
    logic [3:0]       ndig;
    logic [5:0]       pad;
    logic             neg;
    logic             zfill;
    logic             ptr;
    logic             upper;
  } fmt_desc_t;

  typedef enum logic [1:0] {
    FS_IDLE,
    FS_CONV,
    FS_PUSH
  } front_state_t;

  typedef enum logic [2:0] {
    BS_IDLE,
    BS_PFX0,
    BS_PFXX,
    BS_SIGN_PRE,
    BS_PAD,
    BS_SIGN_POST,
    BS_DIG
  } back_state_t;

  function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
    logic [7:0] base;
    base = upper ? CharUpA : CharLowA;
    if (d < 4'd10) begin
      digit_char = CharZero + {4'b0, d};
    end else begin
      digit_char = base + {4'b0, d} - 8'd10;
    end
  endfunction

endpackage

`default_nettype wire

>>> src/iff_front.sv
// front end: takes a request, classifies it and extracts its digits
`timescale 1ns / 1ps
`default_nettype none

module iff_front #(
  parameter int MAX_WIDTH = 63
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  input  wire logic [39:0]       in_tdata,
  input  wire logic [2:0]        in_tuser,
  output logic                   push,
  input  wire logic              full,
  output iff_pkg::fmt_desc_t     desc
);

  localparam logic [5:0] MaxW = 6'(MAX_WIDTH);

  iff_pkg::front_state_t state_r, state_nxt;
  logic [31:0]               num_r, num_nxt;
  logic [iff_pkg::DigsW-1:0] digs_r, digs_nxt;
  logic [3:0]                ndig_r, ndig_nxt;
  logic [5:0]                wid_r, wid_nxt;
  logic                      neg_r, neg_nxt;
  logic                      zfill_r, zfill_nxt;
  logic                      ptr_r, ptr_nxt;
  logic                      upper_r, upper_nxt;
  logic                      hex_r, hex_nxt;

  logic [31:0] value;
  logic [5:0]  width_in;
  logic [5:0]  wid_c;
  logic [63:0] prod;
  logic [31:0] quo;
  logic [31:0] rem;
  logic [3:0]  dig;
  logic [5:0]  total;

  assign value    = in_tdata[31:0];
  assign width_in = in_tdata[37:32];
  assign wid_c    = (width_in > MaxW) ? MaxW : width_in;

  assign prod  = 64'(num_r) * 64'(iff_pkg::DecRecip);
  assign quo   = 32'(prod[63:35]);
  assign rem   = num_r - ((quo << 3) + (quo << 1));
  assign dig   = hex_r ? num_r[3:0] : rem[3:0];
  assign total = {2'b0, ndig_r} + {5'b0, neg_r};

  assign desc.digs  = digs_r;
  assign desc.ndig  = ndig_r;
  assign desc.pad   = (wid_r > total) ? (wid_r - total) : 6'd0;
  assign desc.neg   = neg_r;
  assign desc.zfill = zfill_r;
  assign desc.ptr   = ptr_r;
  assign desc.upper = upper_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= iff_pkg::FS_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    num_r   <= num_nxt;
    digs_r  <= digs_nxt;
    ndig_r  <= ndig_nxt;
    wid_r   <= wid_nxt;
    neg_r   <= neg_nxt;
    zfill_r <= zfill_nxt;
    ptr_r   <= ptr_nxt;
    upper_r <= upper_nxt;
    hex_r   <= hex_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    num_nxt   = num_r;
    digs_nxt  = digs_r;
    ndig_nxt  = ndig_r;
    wid_nxt   = wid_r;
    neg_nxt   = neg_r;
    zfill_nxt = zfill_r;
    ptr_nxt   = ptr_r;
    upper_nxt = upper_r;
    hex_nxt   = hex_r;
    in_tready = 1'b0;
    push      = 1'b0;
    unique case (state_r)
      iff_pkg::FS_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          num_nxt   = value;
          digs_nxt  = '0;
          ndig_nxt  = 4'd0;
          wid_nxt   = wid_c;
          neg_nxt   = 1'b0;
          zfill_nxt = in_tdata[38];
          ptr_nxt   = 1'b0;
          upper_nxt = 1'b0;
          hex_nxt   = 1'b0;
          unique case (in_tuser)
            iff_pkg::KIND_SDEC: begin
              if (value[31]) begin
                neg_nxt = 1'b1;
                num_nxt = 32'd0 - value;
              end
            end
            iff_pkg::KIND_LHEX: hex_nxt = 1'b1;
            iff_pkg::KIND_UHEX: begin
              hex_nxt   = 1'b1;
              upper_nxt = 1'b1;
            end
            iff_pkg::KIND_PTR: begin
              hex_nxt   = 1'b1;
              ptr_nxt   = 1'b1;
              zfill_nxt = 1'b1;
              wid_nxt   = (wid_c > 6'd2) ? (wid_c - 6'd2) : 6'd0;
            end
            default: ;
          endcase
          state_nxt = iff_pkg::FS_CONV;
        end
      end
      iff_pkg::FS_CONV: begin
        digs_nxt = {digs_r[iff_pkg::DigsW-iff_pkg::DigW-1:0], dig};
        ndig_nxt = ndig_r + 4'd1;
        num_nxt  = hex_r ? (num_r >> 4) : quo;
        if (num_nxt == 32'd0) begin
          state_nxt = iff_pkg::FS_PUSH;
        end
      end
      iff_pkg::FS_PUSH: begin
        if (!full) begin
          push      = 1'b1;
          state_nxt = iff_pkg::FS_IDLE;
        end
      end
      default: state_nxt = iff_pkg::FS_IDLE;
    endcase
  end

endmodule

`default_nettype wire

>>> src/iff_queue.sv
// two-entry queue of field descriptors between front and back end
`timescale 1ns / 1ps
`default_nettype none

module iff_queue (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               push,
  input  wire iff_pkg::fmt_desc_t push_desc,
  input  wire logic               pop,
  output iff_pkg::fmt_desc_t      head,
  output logic                    full,
  output logic                    empty
);

  iff_pkg::fmt_desc_t mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  assign full  = (cnt_r == 2'd2);
  assign empty = (cnt_r == 2'd0);
  assign head  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ push;
    rd_ptr_nxt = rd_ptr_r ^ pop;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
    if (push) begin
      mem_r[wr_ptr_r] <= push_desc;
    end
  end

endmodule

`default_nettype wire

>>> src/iff_back.sv
// back end: walks one descriptor and sends its characters
`timescale 1ns / 1ps
`default_nettype none

module iff_back (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire iff_pkg::fmt_desc_t head,
  input  wire logic               empty,
  output logic                    pop,
  output logic                    out_tvalid,
  input  wire logic               out_tready,
  output logic [7:0]              out_tdata,
  output logic                    out_tlast
);

  iff_pkg::back_state_t state_r, state_nxt;
  iff_pkg::fmt_desc_t   cur_r, cur_nxt;
  logic [5:0] pad_r, pad_nxt;
  logic [3:0] idx_r, idx_nxt;
  logic       valid_r, valid_nxt;
  logic [7:0] char_r, char_nxt;
  logic       last_r, last_nxt;
  logic       emit_ok;
  iff_pkg::back_state_t after_lead;

  assign out_tvalid = valid_r;
  assign out_tdata  = char_r;
  assign out_tlast  = last_r;
  assign emit_ok    = !valid_r || out_tready;
  assign after_lead = (pad_r != 6'd0) ? iff_pkg::BS_PAD : iff_pkg::BS_DIG;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= iff_pkg::BS_IDLE;
      valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      valid_r <= valid_nxt;
    end
    cur_r  <= cur_nxt;
    pad_r  <= pad_nxt;
    idx_r  <= idx_nxt;
    char_r <= char_nxt;
    last_r <= last_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    cur_nxt   = cur_r;
    pad_nxt   = pad_r;
    idx_nxt   = idx_r;
    valid_nxt = valid_r && !out_tready;
    char_nxt  = char_r;
    last_nxt  = last_r;
    pop       = 1'b0;
    if (state_r == iff_pkg::BS_IDLE) begin
      if (!empty) begin
        pop     = 1'b1;
        cur_nxt = head;
        pad_nxt = head.pad;
        idx_nxt = head.ndig;
        priority if (head.ptr) begin
          state_nxt = iff_pkg::BS_PFX0;
        end else if (head.neg && head.zfill) begin
          state_nxt = iff_pkg::BS_SIGN_PRE;
        end else if (head.pad != 6'd0) begin
          state_nxt = iff_pkg::BS_PAD;
        end else if (head.neg) begin
          state_nxt = iff_pkg::BS_SIGN_POST;
        end else begin
          state_nxt = iff_pkg::BS_DIG;
        end
      end
    end else if (emit_ok) begin
      valid_nxt = 1'b1;
      last_nxt  = 1'b0;
      unique case (state_r)
        iff_pkg::BS_PFX0: begin
          char_nxt  = iff_pkg::CharZero;
          state_nxt = iff_pkg::BS_PFXX;
        end
        iff_pkg::BS_PFXX: begin
          char_nxt  = iff_pkg::CharX;
          state_nxt = after_lead;
        end
        iff_pkg::BS_SIGN_PRE: begin
          char_nxt  = iff_pkg::CharMinus;
          state_nxt = after_lead;
        end
        iff_pkg::BS_PAD: begin
          char_nxt = cur_r.zfill ? iff_pkg::CharZero : iff_pkg::CharSpace;
          pad_nxt  = pad_r - 6'd1;
          if (pad_r == 6'd1) begin
            state_nxt = (cur_r.neg && !cur_r.zfill) ? iff_pkg::BS_SIGN_POST
                                                    : iff_pkg::BS_DIG;
          end
        end
        iff_pkg::BS_SIGN_POST: begin
          char_nxt  = iff_pkg::CharMinus;
          state_nxt = iff_pkg::BS_DIG;
        end
        iff_pkg::BS_DIG: begin
          char_nxt     = iff_pkg::digit_char(cur_r.digs[iff_pkg::DigW-1:0], cur_r.upper);
          cur_nxt.digs = cur_r.digs >> iff_pkg::DigW;
          idx_nxt      = idx_r - 4'd1;
          if (idx_r == 4'd1) begin
            last_nxt  = 1'b1;
            state_nxt = iff_pkg::BS_IDLE;
          end
        end
        default: begin
          valid_nxt = 1'b0;
          state_nxt = iff_pkg::BS_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

>>> src/integer_field_formatter_top.sv
// top level of the integer field formatter
//
// formats one 32-bit integer per input transaction as ascii text, one
// character per output transaction, with out_tlast on the final character.
// in_tuser selects the conversion: signed or unsigned decimal, lower or upper
// hex, or pointer ("0x" plus zero-filled lower hex, width reduced by two).
// in_tdata carries the value, the minimum field width and the zero-fill flag.
// the front end extracts one digit per cycle (a reciprocal multiply for
// decimal, a nibble for hex), 1 to 10 digits per field, and takes no new
// input until it has pushed the field. a two-entry queue feeds the back end,
// which loads a field and then sends one character per cycle while the
// receiver keeps up.
// when the receiver stalls, the output register holds its character, the
// back end waits, and once the queue fills the front end stops taking input.
// reset empties the queue and drops any field in progress.
`timescale 1ns / 1ps
`default_nettype none

module integer_field_formatter_top #(
  parameter int MAX_WIDTH = 63
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [39:0] in_tdata,   // value[31:0], width[37:32], zero_fill[38], zero
  input  wire logic [2:0]  in_tuser,   // req_type[2:0]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [7:0]       out_tdata,  // out_char[7:0]
  output logic             out_tlast
);

  iff_pkg::fmt_desc_t push_desc;
  iff_pkg::fmt_desc_t head;
  logic q_push;
  logic q_pop;
  logic q_full;
  logic q_empty;

  iff_front #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .push      (q_push),
    .full      (q_full),
    .desc      (push_desc)
  );

  iff_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_desc (push_desc),
    .pop       (q_pop),
    .head      (head),
    .full      (q_full),
    .empty     (q_empty)
  );

  iff_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head),
    .empty      (q_empty),
    .pop        (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  a_push_not_full: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full) else $error("push into full queue");

  a_pop_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_empty) else $error("pop from empty queue");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid) else $error("output valid right after reset");

  a_no_nul_char: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata != 8'h00)) else $error("nul character sent");

endmodule

`default_nettype wire
